// ----- design/kas_pkg.sv -----
`timescale 1ns / 1ps

package kas_pkg;

    // width of the time arithmetic, 16 to 32; timestamps wrap at 2^TIME_BITS
    localparam int TIME_BITS = 32;
    localparam int NOW_BITS  = 32;
    localparam int VAL_BITS  = 16;
    localparam int IDX_BITS  = 3;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [VAL_BITS-1:0]  val_t;

    // signed sum wide enough for target plus or minus a step
    typedef logic signed [VAL_BITS+1:0] sum_t;

    typedef enum logic [IDX_BITS-1:0] {
        REG_DEBOUNCE   = 3'd0,
        REG_LONGPRESS  = 3'd1,
        REG_REPEAT     = 3'd2,
        REG_SHORT_STEP = 3'd3,
        REG_LONG_STEP  = 3'd4,
        REG_MIN_TARGET = 3'd5,
        REG_MAX_TARGET = 3'd6
    } reg_idx_t;

    localparam val_t RST_DEBOUNCE   = 16'd20;
    localparam val_t RST_LONGPRESS  = 16'd500;
    localparam val_t RST_REPEAT     = 16'd120;
    localparam val_t RST_SHORT_STEP = 16'd500;
    localparam val_t RST_LONG_STEP  = 16'd200;
    localparam val_t RST_MIN_TARGET = 16'd16667;
    localparam val_t RST_MAX_TARGET = 16'd50000;
    localparam val_t RST_TARGET     = 16'd30000;

    localparam logic CMD_POLL = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // timing settings seen by each key lane
    typedef struct packed {
        val_t debounce_ms;
        val_t longpress_ms;
        val_t repeat_ms;
    } lane_cfg_t;

    // step settings and clamp range seen by the merge stage
    typedef struct packed {
        val_t short_step_mhz;
        val_t long_step_mhz;
        val_t min_target_mhz;
        val_t max_target_mhz;
    } step_cfg_t;

    // step request from one key lane
    typedef struct packed {
        logic fire;
        logic use_long;
    } step_t;

    typedef struct packed {
        val_t speed_target_mhz;
        logic target_updated;
    } result_t;

    function automatic val_t clamp_target(sum_t x, val_t lo, val_t hi);
        val_t r;
        if (x < $signed({2'b00, lo})) begin
            r = lo;
        end else if (x > $signed({2'b00, hi})) begin
            r = hi;
        end else begin
            r = x[VAL_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// ----- design/kas_in_if.sv -----
`timescale 1ns / 1ps

interface kas_in_if import kas_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                command;
    logic [NOW_BITS-1:0] now_ms;
    logic                up_pressed;
    logic                down_pressed;
    val_t                set_value;

    modport source (output valid, command, now_ms, up_pressed, down_pressed, set_value,
                    input ready);
    modport sink (input valid, command, now_ms, up_pressed, down_pressed, set_value,
                  output ready);
endinterface

// ----- design/kas_out_if.sv -----
`timescale 1ns / 1ps

interface kas_out_if import kas_pkg::*; ();
    logic valid;
    logic ready;
    val_t speed_target_mhz;
    logic target_updated;

    modport source (output valid, speed_target_mhz, target_updated, input ready);
    modport sink (input valid, speed_target_mhz, target_updated, output ready);
endinterface

// ----- design/kas_cfg_if.sv -----
`timescale 1ns / 1ps

interface kas_cfg_if import kas_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IDX_BITS-1:0] index;
    val_t                data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- design/kas_lane.sv -----
`timescale 1ns / 1ps

module kas_lane import kas_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      poll,
    input  time_t     now,
    input  logic      pressed,
    input  lane_cfg_t cfg,
    output step_t     step
);

    logic  stable_reg, stable_next;
    logic  repeat_on_reg, repeat_on_next;
    time_t debounce_start_reg, debounce_start_next;
    time_t press_start_reg, press_start_next;
    time_t repeat_start_reg, repeat_start_next;

    time_t since_debounce;
    time_t since_press;
    time_t since_repeat;

    assign since_debounce = now - debounce_start_reg;
    assign since_press    = now - press_start_reg;
    assign since_repeat   = now - repeat_start_reg;

    always_comb
    begin
        stable_next         = stable_reg;
        repeat_on_next      = repeat_on_reg;
        debounce_start_next = debounce_start_reg;
        press_start_next    = press_start_reg;
        repeat_start_next   = repeat_start_reg;
        step                = '0;
        if (!pressed) begin
            stable_next         = 1'b0;
            repeat_on_next      = 1'b0;
            debounce_start_next = now;
            press_start_next    = '0;
            repeat_start_next   = '0;
        end else if (!stable_reg) begin
            if (since_debounce >= time_t'(cfg.debounce_ms)) begin
                stable_next       = 1'b1;
                repeat_on_next    = 1'b0;
                press_start_next  = now;
                repeat_start_next = now;
                step.fire         = 1'b1;
            end
        end else if (!repeat_on_reg) begin
            // entering auto-repeat only restarts the interval
            if (since_press >= time_t'(cfg.longpress_ms)) begin
                repeat_on_next    = 1'b1;
                repeat_start_next = now;
            end
        end else if (since_repeat >= time_t'(cfg.repeat_ms)) begin
            repeat_start_next = now;
            step.fire         = 1'b1;
            step.use_long     = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stable_reg         <= 1'b0;
            repeat_on_reg      <= 1'b0;
            debounce_start_reg <= '0;
            press_start_reg    <= '0;
            repeat_start_reg   <= '0;
        end else if (poll) begin
            stable_reg         <= stable_next;
            repeat_on_reg      <= repeat_on_next;
            debounce_start_reg <= debounce_start_next;
            press_start_reg    <= press_start_next;
            repeat_start_reg   <= repeat_start_next;
        end
    end

endmodule

// ----- design/kas_merge.sv -----
`timescale 1ns / 1ps

module kas_merge import kas_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  logic      command,
    input  val_t      set_value,
    input  step_t     up_step,
    input  step_t     dn_step,
    input  step_cfg_t cfg,
    output logic      in_ready,
    kas_out_if.source res
);

    val_t    target_reg, target_next;
    result_t out_reg, out_next;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    val_t up_amt, dn_amt;
    sum_t up_sum, dn_sum;
    val_t after_up;
    logic taken;

    assign up_amt = up_step.use_long ? cfg.long_step_mhz : cfg.short_step_mhz;
    assign dn_amt = dn_step.use_long ? cfg.long_step_mhz : cfg.short_step_mhz;

    // up key first, each step clamped on its own
    assign up_sum   = $signed({2'b00, target_reg}) + $signed({2'b00, up_amt});
    assign after_up = up_step.fire
                    ? clamp_target(up_sum, cfg.min_target_mhz, cfg.max_target_mhz)
                    : target_reg;
    assign dn_sum   = $signed({2'b00, after_up}) - $signed({2'b00, dn_amt});

    always_comb
    begin
        if (command == CMD_SET) begin
            target_next = clamp_target($signed({2'b00, set_value}),
                                       cfg.min_target_mhz, cfg.max_target_mhz);
            out_next.target_updated = 1'b0;
        end else begin
            target_next = dn_step.fire
                        ? clamp_target(dn_sum, cfg.min_target_mhz, cfg.max_target_mhz)
                        : after_up;
            out_next.target_updated = up_step.fire | dn_step.fire;
        end
        out_next.speed_target_mhz = target_next;
    end

    assign taken    = out_valid_reg & res.ready;
    assign in_ready = ~skid_valid_reg;

    assign res.valid            = out_valid_reg;
    assign res.speed_target_mhz = out_reg.speed_target_mhz;
    assign res.target_updated   = out_reg.target_updated;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_reg     <= RST_TARGET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                target_reg <= target_next;
            end
            if (taken) begin
                if (skid_valid_reg) begin
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= accept;
                end
            end else if (accept) begin
                if (out_valid_reg) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (taken && skid_valid_reg) begin
            out_reg <= skid_reg;
        end else if (accept && (taken || !out_valid_reg)) begin
            out_reg <= out_next;
        end
        if (accept && out_valid_reg && !taken) begin
            skid_reg <= out_next;
        end
    end

endmodule

// ----- design/key_autorepeat_speed_stepper.sv -----
`timescale 1ns / 1ps
// result: each taken poll or set beat gives one registered result beat
// throughput: one item per cycle while the skid register is empty; the limit
//   is the target loop, two clamped adds (up then down) back into the target register
// reset: settings return to their defaults, target to 30000 mHz, key states
//   clear; the block is ready for items as soon as reset is released

module key_autorepeat_speed_stepper import kas_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    kas_in_if.sink    item,
    kas_cfg_if.sink   cfg,
    kas_out_if.source result
);

    // setting registers
    val_t debounce_reg;
    val_t longpress_reg;
    val_t repeat_reg;
    val_t short_step_reg;
    val_t long_step_reg;
    val_t min_target_reg;
    val_t max_target_reg;

    lane_cfg_t lane_cfg;
    step_cfg_t step_cfg;

    logic  accept;
    logic  poll;
    time_t now;
    step_t up_step;
    step_t dn_step;
    logic  in_ready;

    // settings are always writable
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            debounce_reg   <= RST_DEBOUNCE;
            longpress_reg  <= RST_LONGPRESS;
            repeat_reg     <= RST_REPEAT;
            short_step_reg <= RST_SHORT_STEP;
            long_step_reg  <= RST_LONG_STEP;
            min_target_reg <= RST_MIN_TARGET;
            max_target_reg <= RST_MAX_TARGET;
        end else if (cfg.valid) begin
            case (cfg.index)
                REG_DEBOUNCE:   debounce_reg   <= cfg.data;
                REG_LONGPRESS:  longpress_reg  <= cfg.data;
                REG_REPEAT:     repeat_reg     <= cfg.data;
                REG_SHORT_STEP: short_step_reg <= cfg.data;
                REG_LONG_STEP:  long_step_reg  <= cfg.data;
                REG_MIN_TARGET: min_target_reg <= cfg.data;
                REG_MAX_TARGET: max_target_reg <= cfg.data;
                default:        ; // unmapped index, write dropped
            endcase
        end
    end

    assign lane_cfg.debounce_ms  = debounce_reg;
    assign lane_cfg.longpress_ms = longpress_reg;
    assign lane_cfg.repeat_ms    = repeat_reg;

    assign step_cfg.short_step_mhz = short_step_reg;
    assign step_cfg.long_step_mhz  = long_step_reg;
    assign step_cfg.min_target_mhz = min_target_reg;
    assign step_cfg.max_target_mhz = max_target_reg;

    assign item.ready = in_ready;
    assign accept     = item.valid & in_ready;

    // key states only move on a poll beat; a set beat leaves them alone
    assign poll = accept & (item.command == CMD_POLL);

    // only the low time bits take part in elapsed-time math
    assign now = item.now_ms[TIME_BITS-1:0];

    // one lane per key, both judge the same timestamp side by side
    kas_lane u_lane_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .poll    (poll),
        .now     (now),
        .pressed (item.up_pressed),
        .cfg     (lane_cfg),
        .step    (up_step)
    );

    kas_lane u_lane_dn (
        .clk     (clk),
        .rst_n   (rst_n),
        .poll    (poll),
        .now     (now),
        .pressed (item.down_pressed),
        .cfg     (lane_cfg),
        .step    (dn_step)
    );

    // merge applies up then down to the shared target, output reg plus skid
    kas_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .command   (item.command),
        .set_value (item.set_value),
        .up_step   (up_step),
        .dn_step   (dn_step),
        .cfg       (step_cfg),
        .in_ready  (in_ready),
        .res       (result)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import kas_pkg::*;

    // register index that maps to nothing, writes to it must be dropped
    localparam logic [IDX_BITS-1:0] REG_UNUSED = 3'd7;

    // one poll or set beat as it goes onto the item channel
    typedef struct packed {
        logic                command;
        logic [NOW_BITS-1:0] now_ms;
        logic                up_pressed;
        logic                down_pressed;
        val_t                set_value;
    } poll_beat_t;

    // directed row: the beat plus an optional hand-typed expectation
    typedef struct packed {
        logic                command;
        logic [NOW_BITS-1:0] now_ms;
        logic                up_pressed;
        logic                down_pressed;
        val_t                set_value;
        logic                typed;
        val_t                exp_target;
        logic                exp_updated;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;

    kas_in_if  item_if ();
    kas_cfg_if cfg_if ();
    kas_out_if res_if ();

    key_autorepeat_speed_stepper dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_if),
        .cfg    (cfg_if),
        .result (res_if)
    );

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // speed target predictor: settings, per-key timers and the target
    // ---------------------------------------------------------------
    val_t  debounce_set;
    val_t  longpress_set;
    val_t  repeat_set;
    val_t  short_step_set;
    val_t  long_step_set;
    val_t  floor_set;
    val_t  ceiling_set;

    logic  key_settled [2];
    logic  key_repeating [2];
    time_t settle_since [2];
    time_t hold_since [2];
    time_t repeat_since [2];
    val_t  speed_now;

    // results still owed by the block, oldest first
    result_t pending_speeds[$];

    int mismatches = 0;
    int idle_pct = 38;

    // random-walk state of the stimulus
    logic [NOW_BITS-1:0] clock_ms;
    logic                up_level;
    logic                down_level;

    // clamp as the block does it: below the floor wins over above the ceiling
    function automatic val_t clamp_speed(int x);
        if (x < int'(floor_set))
            return floor_set;
        if (x > int'(ceiling_set))
            return ceiling_set;
        return val_t'(x);
    endfunction

    // one key lane, returns 1 when it reprogrammed the target
    function automatic logic poll_key(int k, logic pressed, time_t now, int sign);
        if (!pressed) begin
            // release clears the lane and restarts the debounce window
            key_settled[k]   = 1'b0;
            key_repeating[k] = 1'b0;
            settle_since[k]  = now;
            hold_since[k]    = '0;
            repeat_since[k]  = '0;
            return 1'b0;
        end
        if (!key_settled[k]) begin
            if (time_t'(now - settle_since[k]) < time_t'(debounce_set))
                return 1'b0;
            key_settled[k]   = 1'b1;
            key_repeating[k] = 1'b0;
            hold_since[k]    = now;
            repeat_since[k]  = now;
            speed_now = clamp_speed(int'(speed_now) + sign * int'(short_step_set));
            return 1'b1;
        end
        if (!key_repeating[k]) begin
            // the beat that enters auto-repeat only arms the interval
            if (time_t'(now - hold_since[k]) >= time_t'(longpress_set)) begin
                key_repeating[k] = 1'b1;
                repeat_since[k]  = now;
            end
            return 1'b0;
        end
        if (time_t'(now - repeat_since[k]) >= time_t'(repeat_set)) begin
            repeat_since[k] = now;
            speed_now = clamp_speed(int'(speed_now) + sign * int'(long_step_set));
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic result_t predict_speed(poll_beat_t b);
        result_t r;
        logic    up_hit;
        logic    down_hit;
        time_t   now;
        now = time_t'(b.now_ms);
        up_hit = 1'b0;
        down_hit = 1'b0;
        if (b.command == CMD_SET) begin
            // keys are not looked at, their lanes keep state
            speed_now = clamp_speed(int'(b.set_value));
        end else begin
            up_hit   = poll_key(0, b.up_pressed, now, 1);
            down_hit = poll_key(1, b.down_pressed, now, -1);
        end
        r.speed_target_mhz = speed_now;
        r.target_updated   = up_hit | down_hit;
        return r;
    endfunction

    task automatic reset_predictor();
        int k;
        debounce_set   = RST_DEBOUNCE;
        longpress_set  = RST_LONGPRESS;
        repeat_set     = RST_REPEAT;
        short_step_set = RST_SHORT_STEP;
        long_step_set  = RST_LONG_STEP;
        floor_set      = RST_MIN_TARGET;
        ceiling_set    = RST_MAX_TARGET;
        for (k = 0; k < 2; k++) begin
            key_settled[k]   = 1'b0;
            key_repeating[k] = 1'b0;
            settle_since[k]  = '0;
            hold_since[k]    = '0;
            repeat_since[k]  = '0;
        end
        speed_now = RST_TARGET;
    endtask

    // ---------------------------------------------------------------
    // item side: drive at the falling edge, take the beat at the rising
    // ---------------------------------------------------------------
    task automatic send_beat(poll_beat_t b, logic typed, result_t typed_res);
        result_t r;
        while ($urandom_range(99, 0) < idle_pct) begin
            item_if.valid = 1'b0;
            @(negedge clk);
        end
        item_if.valid        = 1'b1;
        item_if.command      = b.command;
        item_if.now_ms       = b.now_ms;
        item_if.up_pressed   = b.up_pressed;
        item_if.down_pressed = b.down_pressed;
        item_if.set_value    = b.set_value;
        @(posedge clk);
        while (!item_if.ready)
            @(posedge clk);
        // beat taken on this edge, predictor always runs to keep its state
        r = predict_speed(b);
        pending_speeds.push_back(typed ? typed_res : r);
        @(negedge clk);
    endtask

    // hold the item channel quiet until every owed result has come back
    task automatic drain_results();
        item_if.valid = 1'b0;
        while (pending_speeds.size() != 0)
            @(negedge clk);
    endtask

    // settings are written only with the block idle
    task automatic write_setting(logic [IDX_BITS-1:0] idx, val_t v);
        drain_results();
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data  = v;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            REG_DEBOUNCE:   debounce_set   = v;
            REG_LONGPRESS:  longpress_set  = v;
            REG_REPEAT:     repeat_set     = v;
            REG_SHORT_STEP: short_step_set = v;
            REG_LONG_STEP:  long_step_set  = v;
            REG_MIN_TARGET: floor_set      = v;
            REG_MAX_TARGET: ceiling_set    = v;
            default: ;
        endcase
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic write_all_settings(val_t deb, val_t lp, val_t rep, val_t ss, val_t ls,
                                      val_t lo, val_t hi);
        write_setting(REG_DEBOUNCE, deb);
        write_setting(REG_LONGPRESS, lp);
        write_setting(REG_REPEAT, rep);
        write_setting(REG_SHORT_STEP, ss);
        write_setting(REG_LONG_STEP, ls);
        write_setting(REG_MIN_TARGET, lo);
        write_setting(REG_MAX_TARGET, hi);
    endtask

    // key presses held over many polls with a clock that moves on at a pace
    // matched to the timing settings, so debounce, long-press and repeat are
    // all reached; a few beats glitch a key, jump the clock or load a target
    task automatic run_key_traffic(int n);
        poll_beat_t  b;
        int unsigned pace;
        int          i;
        pace = int'(debounce_set);
        if (longpress_set > pace)
            pace = int'(longpress_set);
        if (repeat_set > pace)
            pace = int'(repeat_set);
        pace = pace / 3 + 3;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99, 0) < 4)
                up_level = ~up_level;
            if ($urandom_range(99, 0) < 4)
                down_level = ~down_level;
            if ($urandom_range(99, 0) < 2)
                clock_ms = $urandom();
            else
                clock_ms = clock_ms + $urandom_range(pace, 0);
            b.command      = ($urandom_range(99, 0) < 5) ? CMD_SET : CMD_POLL;
            b.now_ms       = clock_ms;
            b.up_pressed   = up_level ^ ($urandom_range(99, 0) < 3);
            b.down_pressed = down_level ^ ($urandom_range(99, 0) < 3);
            case ($urandom_range(9, 0))
                0:       b.set_value = '0;
                1:       b.set_value = '1;
                default: b.set_value = val_t'($urandom_range(65535, 0));
            endcase
            send_beat(b, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // result side: random back-pressure, compare against oldest owed
    // ---------------------------------------------------------------
    task automatic flag_mismatch(string what, int unsigned want, int unsigned got);
        if (mismatches < 10)
            $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
        mismatches++;
    endtask

    always @(negedge clk)
        res_if.ready = ($urandom_range(99, 0) >= idle_pct);

    always @(posedge clk) begin
        result_t want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_speeds.size() == 0) begin
                flag_mismatch("unexpected result beat, target", 0,
                              int'(res_if.speed_target_mhz));
            end else begin
                want = pending_speeds.pop_front();
                if (res_if.speed_target_mhz !== want.speed_target_mhz)
                    flag_mismatch("speed_target_mhz", int'(want.speed_target_mhz),
                                  int'(res_if.speed_target_mhz));
                if (res_if.target_updated !== want.target_updated)
                    flag_mismatch("target_updated", int'(want.target_updated),
                                  int'(res_if.target_updated));
            end
        end
    end

    // ---------------------------------------------------------------
    // directed rows, walked in order right after reset with defaults
    // ---------------------------------------------------------------
    directed_row_t opening_rows [23];

    initial begin
        opening_rows = '{
            // after reset: idle poll shows the reset target
            '{CMD_POLL, 32'd0, 1'b0, 1'b0, 16'd0, 1'b1, 16'd30000, 1'b0},
            // set command clamps to floor and ceiling
            '{CMD_SET, 32'd0, 1'b0, 1'b0, 16'd0, 1'b1, 16'd16667, 1'b0},
            '{CMD_SET, 32'd0, 1'b0, 1'b0, 16'hFFFF, 1'b1, 16'd50000, 1'b0},
            '{CMD_SET, 32'd0, 1'b0, 1'b0, 16'd30000, 1'b1, 16'd30000, 1'b0},
            // up held: inside debounce, at debounce, around long-press, repeat
            '{CMD_POLL, 32'd10, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd20, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd519, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd520, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd639, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd640, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            // down joins in while up repeats
            '{CMD_POLL, 32'd760, 1'b1, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            // set while both keys are down leaves the lanes alone
            '{CMD_SET, 32'd770, 1'b1, 1'b1, 16'd49900, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd880, 1'b1, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            // step pinned at the ceiling still flags an update
            '{CMD_POLL, 32'd1000, 1'b1, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            // debounce window across the timestamp wrap
            '{CMD_POLL, 32'hFFFF_FFF0, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd3, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd4, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            // down repeat runs into the floor
            '{CMD_SET, 32'd5, 1'b0, 1'b1, 16'd16700, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd504, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd624, 1'b0, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            // both keys settle on the same poll, up then down
            '{CMD_POLL, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd0, 1'b1, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0},
            '{CMD_POLL, 32'd25, 1'b1, 1'b1, 16'd0, 1'b0, 16'd0, 1'b0}
        };
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial begin
        poll_beat_t b;
        result_t    typed_res;

        rst_n                = 1'b0;
        item_if.valid        = 1'b0;
        item_if.command      = CMD_POLL;
        item_if.now_ms       = '0;
        item_if.up_pressed   = 1'b0;
        item_if.down_pressed = 1'b0;
        item_if.set_value    = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        res_if.ready         = 1'b0;
        clock_ms             = '0;
        up_level             = 1'b0;
        down_level           = 1'b0;
        reset_predictor();

        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        foreach (opening_rows[i]) begin
            b.command      = opening_rows[i].command;
            b.now_ms       = opening_rows[i].now_ms;
            b.up_pressed   = opening_rows[i].up_pressed;
            b.down_pressed = opening_rows[i].down_pressed;
            b.set_value    = opening_rows[i].set_value;
            typed_res.speed_target_mhz = opening_rows[i].exp_target;
            typed_res.target_updated   = opening_rows[i].exp_updated;
            send_beat(b, opening_rows[i].typed, typed_res);
        end
        clock_ms = 32'd100;

        // default settings
        run_key_traffic(160);

        // zero timing, widest steps and range; plus a write to a dead index
        write_all_settings(16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
        write_setting(REG_UNUSED, 16'hA5A5);
        run_key_traffic(120);

        // short timing, narrow range, and a stretch with no idling anywhere
        idle_pct = 0;
        write_all_settings(16'd3, 16'd10, 16'd4, 16'd1000, 16'd300, 16'd1000, 16'd5000);
        run_key_traffic(160);
        idle_pct = 38;

        // floor above ceiling
        write_all_settings(16'd5, 16'd40, 16'd10, 16'd7000, 16'd3000, 16'd40000, 16'd20000);
        run_key_traffic(120);

        // longest timing, smallest steps
        write_all_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd0, 16'hFFFF);
        run_key_traffic(120);

        // random settings
        write_all_settings(val_t'($urandom_range(200, 0)), val_t'($urandom_range(1000, 0)),
                           val_t'($urandom_range(300, 0)), val_t'($urandom_range(65535, 0)),
                           val_t'($urandom_range(65535, 0)), val_t'($urandom_range(30000, 0)),
                           val_t'($urandom_range(65535, 30000)));
        write_setting(REG_UNUSED, val_t'($urandom_range(65535, 0)));
        run_key_traffic(170);

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
